// ===== design/wles_pkg.sv =====
// Shared types, codes and microcode table of the weekly light event scheduler.
`default_nettype none

package wles_pkg;

    localparam int EVENT_SLOTS_DEF = 64;
    localparam int LIGHTS_DEF      = 32;

    // Input command codes.
    localparam logic [1:0] CMD_ON     = 2'd0;
    localparam logic [1:0] CMD_OFF    = 2'd1;
    localparam logic [1:0] CMD_REMOVE = 2'd2;
    localparam logic [1:0] CMD_TICK   = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Day codes.
    localparam logic [3:0] DAY_SUN     = 4'd0;
    localparam logic [3:0] DAY_MON     = 4'd1;
    localparam logic [3:0] DAY_FRI     = 4'd5;
    localparam logic [3:0] DAY_SAT     = 4'd6;
    localparam logic [3:0] DAY_EVERY   = 4'd7;
    localparam logic [3:0] DAY_WORK    = 4'd8;
    localparam logic [3:0] DAY_WEEKEND = 4'd9;

    typedef struct packed {
        logic [7:0]  light;
        logic [3:0]  day;
        logic [10:0] minute;
        logic        on;
    } slot_t;

    // Program steps of the sequencer.
    typedef enum logic [2:0] {
        P_IDLE,
        P_SCHED,
        P_RMV,
        P_TICK,
        P_RESP,
        P_FLUSH
    } step_t;

    // Datapath operation selected by a control word.
    typedef enum logic [2:0] {
        U_LATCH,
        U_FREE,
        U_RMV,
        U_TICK,
        U_RESP,
        U_FLUSH
    } uop_t;

    // Jump condition selected by a control word.
    typedef enum logic [1:0] {
        C_DISPATCH,
        C_SCHED_DONE,
        C_SCAN_DONE,
        C_OUT_FREE
    } cond_t;

    typedef struct packed {
        logic  take;
        uop_t  uop;
        cond_t cond;
        step_t target;
    } ctrl_t;

    function automatic ctrl_t ucode_rom(step_t pc);
        ctrl_t w;
        unique case (pc)
            P_IDLE:  w = '{take: 1'b1, uop: U_LATCH, cond: C_DISPATCH,   target: P_IDLE};
            P_SCHED: w = '{take: 1'b0, uop: U_FREE,  cond: C_SCHED_DONE, target: P_RESP};
            P_RMV:   w = '{take: 1'b0, uop: U_RMV,   cond: C_SCAN_DONE,  target: P_RESP};
            P_TICK:  w = '{take: 1'b0, uop: U_TICK,  cond: C_SCAN_DONE,  target: P_FLUSH};
            P_RESP:  w = '{take: 1'b0, uop: U_RESP,  cond: C_OUT_FREE,   target: P_IDLE};
            P_FLUSH: w = '{take: 1'b0, uop: U_FLUSH, cond: C_OUT_FREE,   target: P_IDLE};
            default: w = '{take: 1'b1, uop: U_LATCH, cond: C_DISPATCH,   target: P_IDLE};
        endcase
        return w;
    endfunction

    // First program step of each command.
    function automatic step_t dispatch(logic [1:0] cmd);
        step_t s;
        unique case (cmd) inside
            CMD_ON, CMD_OFF: s = P_SCHED;
            CMD_REMOVE:      s = P_RMV;
            default:         s = P_TICK;
        endcase
        return s;
    endfunction

    function automatic logic slot_due(slot_t s, logic [3:0] today, logic [10:0] minute);
        logic day_ok;
        day_ok = (s.day == DAY_EVERY) || (s.day == today)
              || (s.day == DAY_WEEKEND && (today == DAY_SUN || today == DAY_SAT))
              || (s.day == DAY_WORK && today >= DAY_MON && today <= DAY_FRI);
        return (s.minute == minute) && day_ok;
    endfunction

endpackage

`default_nettype wire

// ===== design/weekly_light_event_scheduler_unit.sv =====
// Weekly light event scheduler: slot table, microcoded sequencer and result register.
//
// Items enter on the item channel (cmd, light_id, day_code, minute_of_day) and results
// leave on the result channel (status, has_command, light_number, turn_on, last); both
// use a valid/ready transfer. One item is worked on at a time.
// A schedule item walks the valid bits from slot 0 to the first free slot and writes it
// (or reports a full table or a light out of range), then gives one result. A remove or
// tick item reads every slot through the single read port of the slot memory, one slot
// per cycle except while a tick scan is paused as described below.
// A tick gives one result per due slot, in slot order, and marks the last one; if no
// slot is due it gives a single result without a command.
// The result register holds a finished result while the next item is already taken.
// If the receiver stalls during a tick, the scan pauses once a due slot is waiting
// behind a full result register, and resumes when that result is transferred.
// Reset empties the table at once through its valid bits; no clearing pass is needed,
// and the block takes an item in the first cycle after reset.
`default_nettype none

module weekly_light_event_scheduler_unit #(
    parameter int EVENT_SLOTS = wles_pkg::EVENT_SLOTS_DEF,
    parameter int LIGHTS      = wles_pkg::LIGHTS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire logic [1:0]  cmd,
    input  wire logic [7:0]  light_id,
    input  wire logic [3:0]  day_code,
    input  wire logic [10:0] minute_of_day,
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic [1:0]       status,
    output logic             has_command,
    output logic [4:0]       light_number,
    output logic             turn_on,
    output logic             last
);
    import wles_pkg::*;

    localparam int IDXW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
    localparam int CNTW = $clog2(EVENT_SLOTS + 1);

    // Sequencer.
    step_t pc_reg, pc_next;
    ctrl_t ctrl;

    // Latched item.
    logic [1:0]  cmd_reg, cmd_next;
    logic [7:0]  light_reg, light_next;
    logic [3:0]  day_reg, day_next;
    logic [10:0] min_reg, min_next;

    // Scan pointer and read stage.
    logic [CNTW-1:0] iss_reg, iss_next;
    logic            s1_valid_reg, s1_valid_next;
    logic [IDXW-1:0] s1_idx_reg, s1_idx_next;
    logic [1:0]      stat_reg, stat_next;

    // Slot table.
    logic [EVENT_SLOTS-1:0] valid_reg, valid_next;
    slot_t                  mem [EVENT_SLOTS];
    slot_t                  rd_data_reg;
    logic                   rd_en;
    logic                   wr_en;
    slot_t                  wr_data;

    // Pending command of a tick, held until it is known whether it is the last.
    logic       pend_valid_reg, pend_valid_next;
    logic [4:0] pend_light_reg, pend_light_next;
    logic       pend_on_reg, pend_on_next;

    // Result register.
    logic       out_valid_reg, out_valid_next;
    logic [1:0] out_status_reg, out_status_next;
    logic       out_cmd_reg, out_cmd_next;
    logic [4:0] out_light_reg, out_light_next;
    logic       out_on_reg, out_on_next;
    logic       out_last_reg, out_last_next;

    logic            accept;
    logic            out_free;
    logic            light_bad;
    logic [IDXW-1:0] cur_idx;
    logic            slot_free;
    logic            last_slot;
    logic            sched_done;
    logic            issue_more;
    logic            scan_done;
    logic            s1_live;
    logic            rmv_hit;
    logic            tick_hit;
    logic            tick_stall;

    assign ctrl       = ucode_rom(pc_reg);
    assign item_ready = ctrl.take;
    assign accept     = item_valid && ctrl.take;
    assign out_free   = !out_valid_reg || result_ready;

    assign light_bad  = {1'b0, light_reg} >= 9'(LIGHTS);
    assign cur_idx    = iss_reg[IDXW-1:0];
    assign slot_free  = !valid_reg[cur_idx];
    assign last_slot  = iss_reg == CNTW'(EVENT_SLOTS - 1);
    assign sched_done = light_bad || slot_free || last_slot;
    assign issue_more = iss_reg != CNTW'(EVENT_SLOTS);
    assign scan_done  = !issue_more && !s1_valid_reg;

    assign s1_live    = s1_valid_reg && valid_reg[s1_idx_reg];
    assign rmv_hit    = s1_live && rd_data_reg.light == light_reg
                        && rd_data_reg.day == day_reg && rd_data_reg.minute == min_reg;
    assign tick_hit   = s1_live && slot_due(rd_data_reg, day_reg, min_reg);
    // A second due slot cannot be parked while both the pending and result registers are full.
    assign tick_stall = tick_hit && pend_valid_reg && !out_free;

    assign wr_data = '{light: light_reg, day: day_reg, minute: min_reg,
                       on: (cmd_reg == CMD_ON)};

    // Next step of the program.
    always_comb
    begin
        pc_next = pc_reg;
        unique case (ctrl.cond)
            C_DISPATCH:
            begin
                if (accept)
                    pc_next = dispatch(cmd);
            end
            C_SCHED_DONE:
            begin
                if (sched_done)
                    pc_next = ctrl.target;
            end
            C_SCAN_DONE:
            begin
                if (scan_done)
                    pc_next = ctrl.target;
            end
            C_OUT_FREE:
            begin
                if (out_free)
                    pc_next = ctrl.target;
            end
            default: pc_next = P_IDLE;
        endcase
    end

    // Datapath driven by the control word.
    always_comb
    begin
        cmd_next        = cmd_reg;
        light_next      = light_reg;
        day_next        = day_reg;
        min_next        = min_reg;
        iss_next        = iss_reg;
        s1_valid_next   = s1_valid_reg;
        s1_idx_next     = s1_idx_reg;
        stat_next       = stat_reg;
        valid_next      = valid_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        pend_valid_next = pend_valid_reg;
        pend_light_next = pend_light_reg;
        pend_on_next    = pend_on_reg;
        out_valid_next  = out_valid_reg && !result_ready;
        out_status_next = out_status_reg;
        out_cmd_next    = out_cmd_reg;
        out_light_next  = out_light_reg;
        out_on_next     = out_on_reg;
        out_last_next   = out_last_reg;

        unique case (ctrl.uop)
            U_LATCH:
            begin
                if (accept)
                begin
                    cmd_next        = cmd;
                    light_next      = light_id;
                    day_next        = day_code;
                    min_next        = minute_of_day;
                    iss_next        = '0;
                    s1_valid_next   = 1'b0;
                    pend_valid_next = 1'b0;
                end
            end
            U_FREE:
            begin
                if (light_bad)
                    stat_next = ST_RANGE;
                else if (slot_free)
                begin
                    wr_en               = 1'b1;
                    valid_next[cur_idx] = 1'b1;
                    stat_next           = ST_OK;
                end
                else if (last_slot)
                    stat_next = ST_FULL;
                else
                    iss_next = iss_reg + 1'b1;
            end
            U_RMV:
            begin
                if (issue_more)
                begin
                    rd_en         = 1'b1;
                    iss_next      = iss_reg + 1'b1;
                    s1_valid_next = 1'b1;
                    s1_idx_next   = cur_idx;
                end
                else
                    s1_valid_next = 1'b0;
                if (rmv_hit)
                    valid_next[s1_idx_reg] = 1'b0;
                stat_next = ST_OK;
            end
            U_TICK:
            begin
                if (!tick_stall)
                begin
                    if (issue_more)
                    begin
                        rd_en         = 1'b1;
                        iss_next      = iss_reg + 1'b1;
                        s1_valid_next = 1'b1;
                        s1_idx_next   = cur_idx;
                    end
                    else
                        s1_valid_next = 1'b0;
                    if (tick_hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = ST_OK;
                            out_cmd_next    = 1'b1;
                            out_light_next  = pend_light_reg;
                            out_on_next     = pend_on_reg;
                            out_last_next   = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_light_next = rd_data_reg.light[4:0];
                        pend_on_next    = rd_data_reg.on;
                    end
                end
            end
            U_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = stat_reg;
                    out_cmd_next    = 1'b0;
                    out_light_next  = '0;
                    out_on_next     = 1'b0;
                    out_last_next   = 1'b1;
                end
            end
            U_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_OK;
                    out_cmd_next    = pend_valid_reg;
                    out_light_next  = pend_valid_reg ? pend_light_reg : 5'd0;
                    out_on_next     = pend_valid_reg && pend_on_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
                stat_next = ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg         <= P_IDLE;
            iss_reg        <= '0;
            s1_valid_reg   <= 1'b0;
            valid_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pc_reg         <= pc_next;
            iss_reg        <= iss_next;
            s1_valid_reg   <= s1_valid_next;
            valid_reg      <= valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        light_reg      <= light_next;
        day_reg        <= day_next;
        min_reg        <= min_next;
        s1_idx_reg     <= s1_idx_next;
        stat_reg       <= stat_next;
        pend_light_reg <= pend_light_next;
        pend_on_reg    <= pend_on_next;
        out_status_reg <= out_status_next;
        out_cmd_reg    <= out_cmd_next;
        out_light_reg  <= out_light_next;
        out_on_reg     <= out_on_next;
        out_last_reg   <= out_last_next;
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[cur_idx] <= wr_data;
        if (rd_en)
            rd_data_reg <= mem[cur_idx];
    end

    assign result_valid = out_valid_reg;
    assign status       = out_status_reg;
    assign has_command  = out_cmd_reg;
    assign light_number = out_light_reg;
    assign turn_on      = out_on_reg;
    assign last         = out_last_reg;

endmodule

`default_nettype wire

// ===== design/wles_checker.sv =====
// Port-level checker of the weekly light event scheduler and its bind.
`default_nettype none

module wles_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        item_valid,
    input wire logic        item_ready,
    input wire logic [1:0]  cmd,
    input wire logic [7:0]  light_id,
    input wire logic [3:0]  day_code,
    input wire logic [10:0] minute_of_day,
    input wire logic        result_valid,
    input wire logic        result_ready,
    input wire logic [1:0]  status,
    input wire logic        has_command,
    input wire logic [4:0]  light_number,
    input wire logic        turn_on,
    input wire logic        last
);
    import wles_pkg::*;

    // A stalled result keeps its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(status)
        && $stable(has_command) && $stable(light_number) && $stable(turn_on) && $stable(last))
        else $error("result changed while stalled");

    // Only a tick carries a command, and ticks always report ok.
    a_cmd_ok: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && has_command |-> status == ST_OK)
        else $error("command result with non-ok status");

    // A result without a command is the only result of its item.
    a_plain_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !has_command |-> last && light_number == 5'd0 && !turn_on)
        else $error("plain result not marked last or carries light data");

    // One item at a time: after a transfer in, the input is closed in the following cycle.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("second item taken right after the first");

endmodule

bind weekly_light_event_scheduler_unit wles_checker u_wles_checker (.*);

`default_nettype wire

// ===== tb/scheduler_checker.sv =====
// Checker for the light event scheduler: predicts each result from accepted items and compares.
module scheduler_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        item_ready,
    input  logic [1:0]  cmd,
    input  logic [7:0]  light_id,
    input  logic [3:0]  day_code,
    input  logic [10:0] minute_of_day,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic [1:0]  status,
    input  logic        has_command,
    input  logic [4:0]  light_number,
    input  logic        turn_on,
    input  logic        last,
    output int          fail_count,
    output int          outstanding
);
    timeunit 1ns;
    timeprecision 1ps;
    import wles_pkg::*;

    typedef struct packed {
        logic [1:0] status;
        logic       has_command;
        logic [4:0] light;
        logic       on;
        logic       last;
    } reply_t;

    logic   occupied [EVENT_SLOTS_DEF];
    slot_t  booking [EVENT_SLOTS_DEF];
    reply_t awaited_replies [$];
    reply_t want;
    reply_t got;
    int     errors = 0;
    int     replies_seen = 0;

    assign fail_count = errors;

    task automatic report(input string msg);
        errors++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    function automatic logic fires_now(slot_t s, logic [3:0] today, logic [10:0] clock_min);
        logic day_hit;
        if (s.minute != clock_min)
            return 1'b0;
        case (s.day)
            DAY_EVERY:   day_hit = 1'b1;
            DAY_WORK:    day_hit = (today >= DAY_MON && today <= DAY_FRI) || today == DAY_WORK;
            DAY_WEEKEND: day_hit = today == DAY_SUN || today == DAY_SAT || today == DAY_WEEKEND;
            default:     day_hit = s.day == today;
        endcase
        return day_hit;
    endfunction

    // Updates the slot table for one transfer and queues the results it must produce.
    task automatic predict_replies(input logic [1:0] c, input logic [7:0] light,
                                   input logic [3:0] day, input logic [10:0] minute);
        reply_t r;
        int     free_slot;
        int     hits;
        int     n;
        r = '0;
        r.last = 1'b1;
        case (c)
            CMD_ON, CMD_OFF:
            begin
                free_slot = -1;
                if (light >= LIGHTS_DEF)
                begin
                    r.status = ST_RANGE;
                end
                else
                begin
                    for (int k = 0; k < EVENT_SLOTS_DEF; k++)
                        if (!occupied[k] && free_slot < 0)
                            free_slot = k;
                    if (free_slot < 0)
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        booking[free_slot].light  = light;
                        booking[free_slot].day    = day;
                        booking[free_slot].minute = minute;
                        booking[free_slot].on     = (c == CMD_ON);
                        occupied[free_slot] = 1'b1;
                        r.status = ST_OK;
                    end
                end
                awaited_replies.push_back(r);
            end
            CMD_REMOVE:
            begin
                for (int k = 0; k < EVENT_SLOTS_DEF; k++)
                    if (occupied[k] && booking[k].light == light && booking[k].day == day
                        && booking[k].minute == minute)
                        occupied[k] = 1'b0;
                awaited_replies.push_back(r);
            end
            default:
            begin
                hits = 0;
                for (int k = 0; k < EVENT_SLOTS_DEF; k++)
                    if (occupied[k] && fires_now(booking[k], day, minute))
                        hits++;
                if (hits == 0)
                begin
                    awaited_replies.push_back(r);
                end
                else
                begin
                    n = 0;
                    for (int k = 0; k < EVENT_SLOTS_DEF; k++)
                    begin
                        if (occupied[k] && fires_now(booking[k], day, minute))
                        begin
                            r.status      = ST_OK;
                            r.has_command = 1'b1;
                            r.light       = booking[k].light[4:0];
                            r.on          = booking[k].on;
                            r.last        = (n == hits - 1);
                            awaited_replies.push_back(r);
                            n++;
                        end
                    end
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < EVENT_SLOTS_DEF; k++)
                occupied[k] = 1'b0;
            awaited_replies.delete();
            outstanding <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                got = '{status, has_command, light_number, turn_on, last};
                if (awaited_replies.size() == 0)
                begin
                    report($sformatf({"result %0d arrived with nothing expected: ",
                                      "status=%0d cmd=%0b light=%0d on=%0b last=%0b"},
                                     replies_seen, got.status, got.has_command, got.light,
                                     got.on, got.last));
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    if (got !== want)
                        report($sformatf({"result %0d: got status=%0d cmd=%0b light=%0d ",
                                          "on=%0b last=%0b, expected status=%0d cmd=%0b ",
                                          "light=%0d on=%0b last=%0b"},
                                         replies_seen, got.status, got.has_command, got.light,
                                         got.on, got.last, want.status, want.has_command,
                                         want.light, want.on, want.last));
                end
                replies_seen++;
            end
            if (item_valid && item_ready)
                predict_replies(cmd, light_id, day_code, minute_of_day);
            outstanding <= awaited_replies.size();
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the light event scheduler testbench: clock, reset, stimulus, result stalls and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import wles_pkg::*;

    localparam logic [3:0] DAY_TUE     = 4'd2;
    localparam logic [3:0] DAY_INVALID = 4'd15;
    localparam int         LONG_STALL  = 400;

    typedef struct {
        logic [7:0]  light;
        logic [3:0]  day;
        logic [10:0] minute;
    } booking_key_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_ready;
    logic [1:0]  cmd = CMD_TICK;
    logic [7:0]  light_id = '0;
    logic [3:0]  day_code = '0;
    logic [10:0] minute_of_day = '0;
    logic        result_valid;
    logic        result_ready = 1'b0;
    logic [1:0]  status;
    logic        has_command;
    logic [4:0]  light_number;
    logic        turn_on;
    logic        last;

    int           fail_count;
    int           outstanding;
    int           send_idle_pct = 29;
    int           recv_idle_pct = 84;
    bit           stall_request = 1'b0;
    booking_key_t booked [$];

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    weekly_light_event_scheduler_unit i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .cmd           (cmd),
        .light_id      (light_id),
        .day_code      (day_code),
        .minute_of_day (minute_of_day),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .status        (status),
        .has_command   (has_command),
        .light_number  (light_number),
        .turn_on       (turn_on),
        .last          (last)
    );

    scheduler_checker i_checker (.*);

    // Result side: random stalls, plus one long hold-off on request so the block backs up.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (stall_request)
            begin
                stall_request = 1'b0;
                result_ready <= 1'b0;
                for (int stall_cycles = 0; stall_cycles < LONG_STALL; stall_cycles++)
                    @(posedge clk);
            end
            else
            begin
                result_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_item(input logic [1:0] c, input logic [7:0] light,
                             input logic [3:0] day, input logic [10:0] minute);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid    <= 1'b1;
        cmd           <= c;
        light_id      <= light;
        day_code      <= day;
        minute_of_day <= minute;
        do
            @(posedge clk);
        while (!item_ready);
    endtask

    task automatic wait_drained();
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // A small set of minutes keeps ticks landing on booked events.
    function automatic logic [10:0] pick_minute();
        case ($urandom_range(5))
            0:       return 11'd0;
            1:       return 11'd1439;
            2, 3:    return 11'd720;
            4:       return 11'd721;
            default: return 11'($urandom_range(1439));
        endcase
    endfunction

    task automatic send_random(input int sched_pct, input int remove_pct);
        int           pick;
        int           idx;
        booking_key_t key;
        logic [1:0]   c;
        pick = $urandom_range(99);
        if (pick < 5)
        begin
            send_item(2'($urandom_range(3)), 8'($urandom_range(255)), 4'($urandom_range(15)),
                      11'($urandom_range(2047)));
        end
        else if (pick < 5 + sched_pct)
        begin
            key.light  = ($urandom_range(15) == 0) ? 8'($urandom_range(255))
                                                   : 8'($urandom_range(31));
            key.day    = 4'($urandom_range(9));
            key.minute = pick_minute();
            c = $urandom_range(1) ? CMD_ON : CMD_OFF;
            if (key.light < LIGHTS_DEF)
                booked.push_back(key);
            send_item(c, key.light, key.day, key.minute);
        end
        else if (pick < 5 + sched_pct + remove_pct && booked.size() > 0)
        begin
            idx = $urandom_range(booked.size() - 1);
            key = booked[idx];
            booked.delete(idx);
            send_item(CMD_REMOVE, key.light, key.day, key.minute);
        end
        else
        begin
            send_item(CMD_TICK, 8'($urandom_range(255)),
                      ($urandom_range(7) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(6)),
                      pick_minute());
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table, range checks, every day class, odd day and minute values, removal.
        send_item(CMD_TICK,   8'd0,   DAY_SUN,     11'd0);
        send_item(CMD_ON,     8'd0,   DAY_SUN,     11'd0);
        send_item(CMD_OFF,    8'd31,  DAY_SAT,     11'd1439);
        send_item(CMD_ON,     8'd32,  DAY_MON,     11'd0);
        send_item(CMD_OFF,    8'd255, DAY_EVERY,   11'd2047);
        send_item(CMD_ON,     8'd5,   DAY_EVERY,   11'd600);
        send_item(CMD_OFF,    8'd6,   DAY_WORK,    11'd600);
        send_item(CMD_ON,     8'd7,   DAY_WEEKEND, 11'd600);
        send_item(CMD_TICK,   8'd0,   DAY_SUN,     11'd600);
        send_item(CMD_TICK,   8'd0,   DAY_MON,     11'd600);
        send_item(CMD_TICK,   8'd0,   DAY_FRI,     11'd600);
        send_item(CMD_TICK,   8'd0,   DAY_SAT,     11'd600);
        send_item(CMD_TICK,   8'd0,   DAY_SUN,     11'd0);
        send_item(CMD_TICK,   8'd0,   DAY_SAT,     11'd1439);
        send_item(CMD_ON,     8'd9,   DAY_INVALID, 11'd2047);
        send_item(CMD_TICK,   8'd0,   DAY_INVALID, 11'd2047);
        send_item(CMD_TICK,   8'd0,   DAY_WORK,    11'd600);
        send_item(CMD_REMOVE, 8'd6,   DAY_WORK,    11'd600);
        send_item(CMD_TICK,   8'd0,   DAY_MON,     11'd600);
        send_item(CMD_REMOVE, 8'd200, DAY_TUE,     11'd5);
        send_item(CMD_ON,     8'd5,   DAY_EVERY,   11'd600);
        send_item(CMD_REMOVE, 8'd5,   DAY_EVERY,   11'd600);
        send_item(CMD_TICK,   8'd0,   DAY_TUE,     11'd600);

        // Mostly bookings, so the table runs full.
        for (int n = 0; n < 130; n++)
            send_random(70, 5);
        item_valid <= 1'b0;
        wait_drained();

        send_idle_pct = 84;
        recv_idle_pct = 29;
        for (int n = 0; n < 130; n++)
            send_random(25, 40);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int n = 0; n < 130; n++)
        begin
            if (n == 20)
                stall_request = 1'b1;
            send_random(40, 25);
        end
        item_valid <= 1'b0;

        wait_drained();
        repeat (100) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/wles_pkg.sv
design/weekly_light_event_scheduler_unit.sv
design/wles_checker.sv
tb/scheduler_checker.sv
tb/testbench.sv
